// File: sv/rotint_pkg.sv
package rotint_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANG_TABLE_LEN = 24;
    localparam int IDX_W = $clog2(ANG_TABLE_LEN);

    localparam int SAMP_W = 16;
    localparam int FRAC_W = 18;
    localparam int PROD_W = 2 * SAMP_W;
    localparam int REL_W = PROD_W + 2;
    localparam int VX_W = 36;
    localparam int ANG_W = 34;
    localparam int DIFF_W = 33;
    localparam int RX_W = 33;
    localparam int MAG_W = 32;
    localparam int SQ_W = 64;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int SQRT_IDX_W = $clog2(SQRT_STEPS);
    localparam int DIV_STEPS = 17;
    localparam int DIV_IDX_W = $clog2(DIV_STEPS);
    localparam int DIV_W = MAG_W + 16;

    localparam int PIPE_DEPTH = 8 + 2 * CORDIC_STAGES + SQRT_STEPS + DIV_STEPS;
    localparam int SA_LEN = CORDIC_STAGES + 5;

    localparam logic signed [ANG_W-1:0] ANG_PI = ANG_W'(64'sd2147483648);
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(64'sd1073741824);
    localparam logic signed [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
    localparam logic signed [SAMP_W-1:0] UNIT_MAX = 16'sd32767;

    localparam logic [31:0] ATAN_TAB [ANG_TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10680862, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41721, 32'd20860,
        32'd10430, 32'd5215, 32'd2607, 32'd1303,
        32'd651, 32'd325, 32'd162, 32'd81
    };

    typedef struct packed {
        logic                     pass;
        logic signed [SAMP_W-1:0] pcos;
        logic signed [SAMP_W-1:0] psin;
    } pinfo_t;

    typedef struct packed {
        logic signed [SAMP_W-1:0] sc;
        logic signed [SAMP_W-1:0] ss;
        logic signed [FRAC_W-1:0] frac;
    } sa_t;

    typedef struct packed {
        logic             xneg;
        logic             yneg;
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
    } mag_t;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic mzero;
    } dside_t;

endpackage

// File: sv/rotation_interpolator.sv
// channel   | direction | tdata fields, lowest bit up
// s_axis    | in        | start_cos, start_sin, end_cos, end_sin, fraction, zero pad
// m_axis    | out       | out_cos, out_sin
// one beat accepted per cycle while the skid register is empty; 8 + 2*CORDIC_STAGES
// + 32 + 17 pipeline stages plus the output register, set by the two
// cordic cell rows, the square root cell row and the divider cell row
// aresetn clears all valid bits, including those of the output and skid registers
// a stalled output fills the skid register; the pipeline and s_axis_tready
// then hold until the skid register drains
module rotation_interpolator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // start_cos, start_sin, end_cos, end_sin, fraction
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // out_cos, out_sin
);
    import rotint_pkg::*;

    localparam int CS = CORDIC_STAGES;

    logic en;
    logic vld_reg [PIPE_DEPTH];
    pinfo_t pinfo_reg [PIPE_DEPTH];
    sa_t sa_reg [SA_LEN];
    logic yz_reg [CS+1];
    logic yneg_reg [CS+1];
    mag_t mag_reg [SQRT_STEPS+2];
    dside_t ds_reg [DIV_STEPS];

    logic signed [SAMP_W-1:0] in_sc, in_ss, in_ec, in_es;
    logic signed [FRAC_W-1:0] in_f;
    pinfo_t pin_next;
    sa_t sa_next;

    assign in_sc = s_axis_tdata[15:0];
    assign in_ss = s_axis_tdata[31:16];
    assign in_ec = s_axis_tdata[47:32];
    assign in_es = s_axis_tdata[63:48];
    assign in_f = s_axis_tdata[81:64];

    always_comb begin
        sa_next.sc = in_sc;
        sa_next.ss = in_ss;
        sa_next.frac = in_f;
        pin_next.pass = (in_f <= 0) || (in_f >= FRAC_ONE);
        if (in_f <= 0) begin
            pin_next.pcos = in_sc;
            pin_next.psin = in_ss;
        end else begin
            pin_next.pcos = in_ec;
            pin_next.psin = in_es;
        end
    end

    // relative vector products, sum and difference
    logic signed [PROD_W-1:0] p_cc_reg, p_ss_reg, p_ce_reg, p_sc_reg;
    logic signed [REL_W-1:0]  rc_reg, rs_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_cc_reg <= in_sc * in_ec;
            p_ss_reg <= in_ss * in_es;
            p_ce_reg <= in_sc * in_es;
            p_sc_reg <= in_ss * in_ec;
            rc_reg <= REL_W'(p_cc_reg) + REL_W'(p_ss_reg);
            rs_reg <= REL_W'(p_ce_reg) - REL_W'(p_sc_reg);
        end
    end

    // vectoring row
    logic signed [VX_W-1:0]  vx [CS+1];
    logic signed [VX_W-1:0]  vy [CS+1];
    logic signed [ANG_W-1:0] vz [CS+1];
    logic signed [VX_W-1:0]  vx0_reg, vx0_next, vy0_reg, vy0_next, rc_ext, rs_ext;
    logic signed [ANG_W-1:0] vz0_reg, vz0_next;

    assign rc_ext = VX_W'(rc_reg);
    assign rs_ext = VX_W'(rs_reg);

    always_comb begin
        vx0_next = rc_ext;
        vy0_next = rs_ext;
        vz0_next = '0;
        if (rc_reg < 0) begin
            if (rs_reg > 0) begin
                vx0_next = rs_ext;
                vy0_next = -rc_ext;
                vz0_next = ANG_HALF_PI;
            end else begin
                vx0_next = -rs_ext;
                vy0_next = rc_ext;
                vz0_next = -ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vx0_reg <= vx0_next;
            vy0_reg <= vy0_next;
            vz0_reg <= vz0_next;
        end
    end

    assign vx[0] = vx0_reg;
    assign vy[0] = vy0_reg;
    assign vz[0] = vz0_reg;

    for (genvar i = 0; i < CS; i++) begin : g_vec
        rotint_vec_cell u_cell (
            .aclk  (aclk),
            .en    (en),
            .idx   (IDX_W'(i)),
            .x_in  (vx[i]),
            .y_in  (vy[i]),
            .z_in  (vz[i]),
            .x_out (vx[i+1]),
            .y_out (vy[i+1]),
            .z_out (vz[i+1])
        );
    end

    // clamp, scale by fraction, quadrant turn
    logic signed [ANG_W-1:0]         zc;
    logic signed [DIFF_W-1:0]        diff_reg, diff_next;
    logic signed [DIFF_W+FRAC_W-1:0] scl_reg;
    logic signed [DIFF_W+FRAC_W-1:0] scl_sh;
    logic signed [ANG_W-1:0]         phi;
    logic signed [RX_W-1:0]          sx, sy;
    logic signed [RX_W-1:0]          rx0_reg, rx0_next, ry0_reg, ry0_next;
    logic signed [ANG_W-1:0]         rz0_reg, rz0_next;

    always_comb begin
        zc = vz[CS];
        if (zc > ANG_PI) begin
            zc = ANG_PI;
        end else if (zc < -ANG_PI) begin
            zc = -ANG_PI;
        end
        if (yz_reg[CS]) begin
            diff_next = yneg_reg[CS] ? DIFF_W'(ANG_PI) : '0;
        end else begin
            diff_next = DIFF_W'(zc);
        end
    end

    assign scl_sh = scl_reg >>> 16;
    assign phi = scl_sh[ANG_W-1:0];
    assign sx = {{(RX_W-SAMP_W-14){sa_reg[SA_LEN-1].sc[SAMP_W-1]}}, sa_reg[SA_LEN-1].sc, 14'b0};
    assign sy = {{(RX_W-SAMP_W-14){sa_reg[SA_LEN-1].ss[SAMP_W-1]}}, sa_reg[SA_LEN-1].ss, 14'b0};

    always_comb begin
        rx0_next = sx;
        ry0_next = sy;
        rz0_next = phi;
        if (phi > ANG_HALF_PI) begin
            rx0_next = -sy;
            ry0_next = sx;
            rz0_next = phi - ANG_HALF_PI;
        end else if (phi < -ANG_HALF_PI) begin
            rx0_next = sy;
            ry0_next = -sx;
            rz0_next = phi + ANG_HALF_PI;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= diff_next;
            scl_reg <= diff_reg * sa_reg[SA_LEN-2].frac;
            rx0_reg <= rx0_next;
            ry0_reg <= ry0_next;
            rz0_reg <= rz0_next;
        end
    end

    // rotation row
    logic signed [RX_W-1:0]  rx [CS+1];
    logic signed [RX_W-1:0]  ry [CS+1];
    logic signed [ANG_W-1:0] rz [CS+1];

    assign rx[0] = rx0_reg;
    assign ry[0] = ry0_reg;
    assign rz[0] = rz0_reg;

    for (genvar i = 0; i < CS; i++) begin : g_rot
        rotint_rot_cell u_cell (
            .aclk  (aclk),
            .en    (en),
            .idx   (IDX_W'(i)),
            .x_in  (rx[i]),
            .y_in  (ry[i]),
            .z_in  (rz[i]),
            .x_out (rx[i+1]),
            .y_out (ry[i+1]),
            .z_out (rz[i+1])
        );
    end

    // magnitude squared
    logic signed [RX_W-1:0] abx, aby;
    mag_t mag_next;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, nsum_reg;

    assign abx = rx[CS][RX_W-1] ? -rx[CS] : rx[CS];
    assign aby = ry[CS][RX_W-1] ? -ry[CS] : ry[CS];

    always_comb begin
        mag_next.xneg = rx[CS][RX_W-1];
        mag_next.yneg = ry[CS][RX_W-1];
        mag_next.ax = abx[MAG_W-1:0];
        mag_next.ay = aby[MAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg <= mag_next.ax * mag_next.ax;
            sqy_reg <= mag_next.ay * mag_next.ay;
            nsum_reg <= sqx_reg + sqy_reg;
        end
    end

    // square root row
    logic [SQ_W-1:0] sn [SQRT_STEPS+1];
    logic [SQ_W-1:0] sr [SQRT_STEPS+1];

    assign sn[0] = nsum_reg;
    assign sr[0] = '0;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        rotint_sqrt_cell u_cell (
            .aclk  (aclk),
            .en    (en),
            .k     (SQRT_IDX_W'(SQRT_STEPS - 1 - i)),
            .n_in  (sn[i]),
            .r_in  (sr[i]),
            .n_out (sn[i+1]),
            .r_out (sr[i+1])
        );
    end

    // divider rows, one per component
    logic [MAG_W-1:0]     mroot;
    mag_t                 mtail;
    dside_t               ds_next;
    logic [DIV_W-1:0]     xrem [DIV_STEPS+1];
    logic [DIV_W-1:0]     yrem [DIV_STEPS+1];
    logic [MAG_W-1:0]     xd [DIV_STEPS+1];
    logic [MAG_W-1:0]     yd [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] xq [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] yq [DIV_STEPS+1];

    assign mroot = sr[SQRT_STEPS][MAG_W-1:0];
    assign mtail = mag_reg[SQRT_STEPS+1];
    assign xrem[0] = {mtail.ax, 16'b0};
    assign yrem[0] = {mtail.ay, 16'b0};
    assign xd[0] = mroot;
    assign yd[0] = mroot;
    assign xq[0] = '0;
    assign yq[0] = '0;

    always_comb begin
        ds_next.xneg = mtail.xneg;
        ds_next.yneg = mtail.yneg;
        ds_next.mzero = (mroot == '0);
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        rotint_div_cell u_xcell (
            .aclk    (aclk),
            .en      (en),
            .j       (DIV_IDX_W'(DIV_STEPS - 1 - i)),
            .rem_in  (xrem[i]),
            .d_in    (xd[i]),
            .q_in    (xq[i]),
            .rem_out (xrem[i+1]),
            .d_out   (xd[i+1]),
            .q_out   (xq[i+1])
        );
        rotint_div_cell u_ycell (
            .aclk    (aclk),
            .en      (en),
            .j       (DIV_IDX_W'(DIV_STEPS - 1 - i)),
            .rem_in  (yrem[i]),
            .d_in    (yd[i]),
            .q_in    (yq[i]),
            .rem_out (yrem[i+1]),
            .d_out   (yd[i+1]),
            .q_out   (yq[i+1])
        );
    end

    // side registers alongside the rows
    always_ff @(posedge aclk) begin
        if (en) begin
            pinfo_reg[0] <= pin_next;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                pinfo_reg[i] <= pinfo_reg[i-1];
            end
            sa_reg[0] <= sa_next;
            for (int i = 1; i < SA_LEN; i++) begin
                sa_reg[i] <= sa_reg[i-1];
            end
            yz_reg[0] <= (rs_reg == '0);
            yneg_reg[0] <= rc_reg[REL_W-1];
            for (int i = 1; i <= CS; i++) begin
                yz_reg[i] <= yz_reg[i-1];
                yneg_reg[i] <= yneg_reg[i-1];
            end
            mag_reg[0] <= mag_next;
            for (int i = 1; i < SQRT_STEPS + 2; i++) begin
                mag_reg[i] <= mag_reg[i-1];
            end
            ds_reg[0] <= ds_next;
            for (int i = 1; i < DIV_STEPS; i++) begin
                ds_reg[i] <= ds_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // rounding, sign and saturation
    function automatic logic signed [SAMP_W-1:0] unit_out(
        input logic [DIV_STEPS-1:0] q,
        input logic                 neg
    );
        logic [DIV_STEPS:0] qr;
        begin
            qr = ({1'b0, q} + (DIV_STEPS+1)'(1)) >> 1;
            if (neg) begin
                unit_out = -qr[SAMP_W-1:0];
            end else if (qr > (DIV_STEPS+1)'(UNIT_MAX)) begin
                unit_out = UNIT_MAX;
            end else begin
                unit_out = qr[SAMP_W-1:0];
            end
        end
    endfunction

    logic        tail_v;
    logic [31:0] tail_d;
    pinfo_t      ptail;
    dside_t      dtail;

    assign tail_v = vld_reg[PIPE_DEPTH-1];
    assign ptail = pinfo_reg[PIPE_DEPTH-1];
    assign dtail = ds_reg[DIV_STEPS-1];

    always_comb begin
        if (ptail.pass) begin
            tail_d = {ptail.psin, ptail.pcos};
        end else if (dtail.mzero) begin
            tail_d = '0;
        end else begin
            tail_d = {unit_out(yq[DIV_STEPS], dtail.yneg), unit_out(xq[DIV_STEPS], dtail.xneg)};
        end
    end

    // output register and skid
    logic        out_valid_reg, skid_valid_reg;
    logic [31:0] out_data_reg, skid_data_reg;

    assign en = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            if (tail_v) begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_reg <= 1'b1;
                    out_data_reg <= tail_d;
                end else begin
                    skid_valid_reg <= 1'b1;
                    skid_data_reg <= tail_d;
                end
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end else if (m_axis_tready) begin
            out_data_reg <= skid_data_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output is empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready && vld_reg[PIPE_DEPTH-1]))
        else $error("skid filled without a stalled output");

    a_pipe_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg[PIPE_DEPTH-1]))
        else $error("pipeline tail moved during stall");

endmodule

// File: sv/rotint_vec_cell.sv
module rotint_vec_cell (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [rotint_pkg::IDX_W-1:0]        idx,
    input  logic signed [rotint_pkg::VX_W-1:0]  x_in,
    input  logic signed [rotint_pkg::VX_W-1:0]  y_in,
    input  logic signed [rotint_pkg::ANG_W-1:0] z_in,
    output logic signed [rotint_pkg::VX_W-1:0]  x_out,
    output logic signed [rotint_pkg::VX_W-1:0]  y_out,
    output logic signed [rotint_pkg::ANG_W-1:0] z_out
);
    import rotint_pkg::*;

    logic signed [VX_W-1:0]  x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [ANG_W-1:0] z_reg, z_next, atn;

    assign atn = ANG_W'(ATAN_TAB[idx]);
    assign dx = y_in >>> idx;
    assign dy = x_in >>> idx;

    always_comb begin
        if (!y_in[VX_W-1]) begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + atn;
        end else begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - atn;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// File: sv/rotint_rot_cell.sv
module rotint_rot_cell (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [rotint_pkg::IDX_W-1:0]        idx,
    input  logic signed [rotint_pkg::RX_W-1:0]  x_in,
    input  logic signed [rotint_pkg::RX_W-1:0]  y_in,
    input  logic signed [rotint_pkg::ANG_W-1:0] z_in,
    output logic signed [rotint_pkg::RX_W-1:0]  x_out,
    output logic signed [rotint_pkg::RX_W-1:0]  y_out,
    output logic signed [rotint_pkg::ANG_W-1:0] z_out
);
    import rotint_pkg::*;

    logic signed [RX_W-1:0]  x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [ANG_W-1:0] z_reg, z_next, atn;

    assign atn = ANG_W'(ATAN_TAB[idx]);
    assign dx = y_in >>> idx;
    assign dy = x_in >>> idx;

    always_comb begin
        if (!z_in[ANG_W-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - atn;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + atn;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// File: sv/rotint_sqrt_cell.sv
module rotint_sqrt_cell (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [rotint_pkg::SQRT_IDX_W-1:0]   k,
    input  logic [rotint_pkg::SQ_W-1:0]         n_in,
    input  logic [rotint_pkg::SQ_W-1:0]         r_in,
    output logic [rotint_pkg::SQ_W-1:0]         n_out,
    output logic [rotint_pkg::SQ_W-1:0]         r_out
);
    import rotint_pkg::*;

    logic [SQ_W-1:0] n_reg, n_next, r_reg, r_next, bitv, trial;

    assign bitv = SQ_W'(1) << {k, 1'b0};
    assign trial = r_in + bitv;

    always_comb begin
        if (n_in >= trial) begin
            n_next = n_in - trial;
            r_next = (r_in >> 1) + bitv;
        end else begin
            n_next = n_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= n_next;
            r_reg <= r_next;
        end
    end

    assign n_out = n_reg;
    assign r_out = r_reg;

endmodule

// File: sv/rotint_div_cell.sv
module rotint_div_cell (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [rotint_pkg::DIV_IDX_W-1:0]   j,
    input  logic [rotint_pkg::DIV_W-1:0]       rem_in,
    input  logic [rotint_pkg::MAG_W-1:0]       d_in,
    input  logic [rotint_pkg::DIV_STEPS-1:0]   q_in,
    output logic [rotint_pkg::DIV_W-1:0]       rem_out,
    output logic [rotint_pkg::MAG_W-1:0]       d_out,
    output logic [rotint_pkg::DIV_STEPS-1:0]   q_out
);
    import rotint_pkg::*;

    logic [DIV_W-1:0]     rem_reg, rem_next, trial;
    logic [MAG_W-1:0]     d_reg;
    logic [DIV_STEPS-1:0] q_reg, q_next;

    assign trial = DIV_W'(d_in) << j;

    always_comb begin
        if (rem_in >= trial) begin
            rem_next = rem_in - trial;
            q_next = q_in | (DIV_STEPS'(1) << j);
        end else begin
            rem_next = rem_in;
            q_next = q_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            q_reg <= q_next;
            d_reg <= d_in;
        end
    end

    assign rem_out = rem_reg;
    assign d_out = d_reg;
    assign q_out = q_reg;

endmodule

// File: tb/rotation_checker.sv
`timescale 1ns / 1ps

module rotation_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    output int          fail_count,
    output int          pending
);
    import rotint_pkg::*;

    typedef struct packed {
        logic signed [15:0] osin;
        logic signed [15:0] ocos;
    } dir_t;

    dir_t expected_dirs[$];

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint res, bit_v;
        res = 0;
        bit_v = 64'sh4000000000000000;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic longint relative_angle(longint x, longint y);
        longint z, t, dx, dy;
        z = 0;
        if (y == 0) return (x < 0) ? 64'sd2147483648 : 64'sd0;
        if (x < 0) begin
            if (y > 0) begin
                t = x; x = y; y = -t; z = 64'sd1073741824;
            end else begin
                t = x; x = -y; y = t; z = -64'sd1073741824;
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < ANG_TABLE_LEN; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        if (z > 64'sd2147483648) z = 64'sd2147483648;
        if (z < -64'sd2147483648) z = -64'sd2147483648;
        return z;
    endfunction

    function automatic logic signed [15:0] unit_component(longint c, longint m);
        longint a, q, r;
        a = (c < 0) ? -c : c;
        q = ((a * 65536) / m + 1) >> 1;
        r = (c < 0) ? -q : q;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    function automatic dir_t interpolate_dir(logic [87:0] d);
        longint sc, ss, ec, es, f, rc, rs, phi, x, y, t, dx, dy, m;
        dir_t r;
        sc = longint'($signed(d[15:0]));
        ss = longint'($signed(d[31:16]));
        ec = longint'($signed(d[47:32]));
        es = longint'($signed(d[63:48]));
        f = longint'($signed(d[81:64]));
        if (f <= 0) begin
            r.ocos = 16'(sc); r.osin = 16'(ss);
        end else if (f >= 65536) begin
            r.ocos = 16'(ec); r.osin = 16'(es);
        end else begin
            rc = sc * ec + ss * es;
            rs = sc * es - ss * ec;
            phi = floor_shift(relative_angle(rc, rs) * f, 16);
            x = sc * 16384;
            y = ss * 16384;
            if (phi > 64'sd1073741824) begin
                t = x; x = -y; y = t; phi -= 64'sd1073741824;
            end else if (phi < -64'sd1073741824) begin
                t = x; x = y; y = -t; phi += 64'sd1073741824;
            end
            for (int i = 0; i < CORDIC_STAGES && i < ANG_TABLE_LEN; i++) begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (phi >= 0) begin
                    x -= dx; y += dy; phi -= longint'(ATAN_TAB[i]);
                end else begin
                    x += dx; y -= dy; phi += longint'(ATAN_TAB[i]);
                end
            end
            m = int_sqrt(x * x + y * y);
            if (m == 0) begin
                r = '0;
            end else begin
                r.ocos = unit_component(x, m);
                r.osin = unit_component(y, m);
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        dir_t want, got;
        if (!aresetn) begin
            fail_count = 0;
            pending = 0;
            expected_dirs.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_dirs.push_back(interpolate_dir(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_dirs.size() == 0) begin
                    $error("unexpected beat %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_dirs.pop_front();
                    if (got.ocos !== want.ocos) begin
                        $error("out_cos expected %0d actual %0d", want.ocos, got.ocos);
                        fail_count++;
                    end
                    if (got.osin !== want.osin) begin
                        $error("out_sin expected %0d actual %0d", want.osin, got.osin);
                        fail_count++;
                    end
                end
            end
            pending = expected_dirs.size();
        end
    end
endmodule

// File: tb/tb_rotation_interpolator.sv
`timescale 1ns / 1ps

module tb_rotation_interpolator;
    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;

    rotation_interpolator dut (.*);

    rotation_checker u_checker (.*);

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [17:0] rand_frac();
        case ($urandom_range(0, 9))
            0: return 18'($signed($urandom_range(0, 8)) - 4);
            1: return 18'(65536 + $urandom_range(0, 4) - 2);
            2: return 18'($urandom);
            default: return 18'($urandom_range(1, 65535));
        endcase
    endfunction

    // tvalid stays up after the beat; the next call drops it while idling, else the caller does
    task automatic send_beat(logic [15:0] sc, logic [15:0] ss, logic [15:0] ec,
                             logic [15:0] es, logic [17:0] f);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, f, es, ec, ss, sc};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int idle_set[4][2];
        int wait_cycles;
        idle_set = '{'{0, 0}, '{46, 0}, '{0, 46}, '{19, 19}};
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_beat(16'h7fff, 16'h0000, 16'h0000, 16'h7fff, 18'h08000);
        send_beat(16'h7fff, 16'h0000, 16'h8000, 16'h0000, 18'h08000);
        send_beat(16'h7fff, 16'h0000, 16'h8000, 16'h0001, 18'h0ffff);
        send_beat(16'h7fff, 16'h0000, 16'h8000, 16'hffff, 18'h00001);
        send_beat(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 18'h08000);
        send_beat(16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 18'h04000);
        send_beat(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 18'h00000);
        send_beat(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 18'h3ffff);
        send_beat(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 18'h20000);
        send_beat(16'h1234, 16'h5678, 16'h8000, 16'h7fff, 18'h10000);
        send_beat(16'h1234, 16'h5678, 16'h8000, 16'h7fff, 18'h1ffff);
        send_beat(16'h0001, 16'h0000, 16'h0000, 16'hffff, 18'h0c000);
        send_beat(16'h8000, 16'h0000, 16'h0000, 16'h8000, 18'h0c000);
        send_beat(16'h0000, 16'h8000, 16'h0000, 16'h7fff, 18'h0ffff);
        send_beat(16'h5a82, 16'h5a82, 16'ha57e, 16'ha57e, 18'h0aaaa);
        send_beat(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 18'h0fff0);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_set[ph][0];
            recv_stall_pct = idle_set[ph][1];
            for (int n = 0; n < 275; n++)
                send_beat(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_frac());
            if (ph == 1) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (400) @(negedge aclk);
                        hold_off = 1'b0;
                    end
                    begin
                        for (int n = 0; n < 150; n++)
                            send_beat(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                                      rand_frac());
                        s_axis_tvalid <= 1'b0;
                    end
                join
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            wait_cycles = 0;
            while (pending != 0 && wait_cycles < 100000) begin
                @(negedge aclk);
                wait_cycles++;
            end
        end

        repeat (200) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: sim.f
sv/rotint_pkg.sv
sv/rotint_vec_cell.sv
sv/rotint_rot_cell.sv
sv/rotint_sqrt_cell.sv
sv/rotint_div_cell.sv
sv/rotation_interpolator.sv
tb/rotation_checker.sv
tb/tb_rotation_interpolator.sv
